FILE: rtl/pbra_pkg.sv
// Package: shared constants, codes and controller/datapath types of the page allocator.
`default_nettype none
package pbra_pkg;

	localparam int MAX_PAGES_DEF = 1024;
	localparam int CNT_W         = 11;
	localparam int ADDR_W        = 48;
	localparam int BYTES_W       = 32;
	localparam int PAGE_SHIFT    = 12;
	localparam int PAGE_BYTES    = 4096;
	localparam int REG_IDX_W     = 2;

	localparam logic [REG_IDX_W-1:0] REG_ARENA_ENABLE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_ARENA_PAGES  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_ARENA_BASE   = 2'd2;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START_HI,
		ST_SCAN_HI,
		ST_START_LO,
		ST_SCAN_LO,
		ST_FREE_RD,
		ST_FREE_CHK,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_ACCEPT,
		OP_START_HI,
		OP_START_LO,
		OP_SCAN,
		OP_RELEASE,
		OP_WALK,
		OP_FINISH
	} op_t;

	typedef struct packed {
		logic clear_done;
		logic is_free;
		logic alloc_ok;
		logic free_ok;
		logic found;
		logic scan_end;
		logic lo_empty;
		logic run_zero;
		logic walk_done;
		logic out_busy;
	} stat_t;

endpackage
`default_nettype wire

FILE: rtl/page_bitmap_run_allocator_top.sv
// Top level: contiguous next-fit page allocator over a bitmap of 4 KB pages.
// After reset the block clears its page bitmap and run-length stores before
// it takes the first request; configuration writes are taken throughout. An
// allocate scans the bitmap RAM, one read per cycle, from the hint up to the
// effective arena size and, when the search wraps, from page zero up to the
// hint, then marks each page of the run it found; an allocate that fails its
// checks goes straight to the result without a scan. A free reads the run
// length stored for its page and releases each page of that run. One request
// is in work at a time; a finished result waits in the output register while
// the next request is accepted.
`default_nettype none
module page_bitmap_run_allocator_top #(
	parameter int MAX_PAGES = pbra_pkg::MAX_PAGES_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire [pbra_pkg::REG_IDX_W-1:0]    cfg_index,
	input  wire [pbra_pkg::ADDR_W-1:0]       cfg_data,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire                              req_type,
	input  wire [pbra_pkg::BYTES_W-1:0]      request_bytes,
	input  wire [pbra_pkg::ADDR_W-1:0]       free_address,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic                             granted,
	output logic [pbra_pkg::ADDR_W-1:0]      granted_address,
	output logic [pbra_pkg::CNT_W-1:0]       pages_released,
	output logic [pbra_pkg::CNT_W-1:0]       live_count,
	output logic [pbra_pkg::CNT_W-1:0]       peak_count
);
	pbra_pkg::op_t   op;
	pbra_pkg::stat_t st;

	pbra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.op       (op)
	);

	pbra_dp #(.MAX_PAGES(MAX_PAGES)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.req_type        (req_type),
		.request_bytes   (request_bytes),
		.free_address    (free_address),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.granted         (granted),
		.granted_address (granted_address),
		.pages_released  (pages_released),
		.live_count      (live_count),
		.peak_count      (peak_count),
		.op              (op),
		.st              (st)
	);
endmodule
`default_nettype wire

FILE: rtl/pbra_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module pbra_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/pbra_ctrl.sv
// Controller: request sequencing state machine.
`default_nettype none
module pbra_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_ready,
	input  pbra_pkg::stat_t st,
	output pbra_pkg::op_t   op
);
	pbra_pkg::state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbra_pkg::ST_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		op       = pbra_pkg::OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			pbra_pkg::ST_CLEAR: begin
				op = pbra_pkg::OP_CLEAR;
				if (st.clear_done) state_n = pbra_pkg::ST_IDLE;
			end
			pbra_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op = pbra_pkg::OP_ACCEPT;
					if (st.is_free) begin
						state_n = st.free_ok ? pbra_pkg::ST_FREE_RD : pbra_pkg::ST_DONE;
					end else begin
						state_n = st.alloc_ok ? pbra_pkg::ST_START_HI : pbra_pkg::ST_DONE;
					end
				end
			end
			pbra_pkg::ST_START_HI: begin
				op      = pbra_pkg::OP_START_HI;
				state_n = pbra_pkg::ST_SCAN_HI;
			end
			pbra_pkg::ST_SCAN_HI: begin
				op = pbra_pkg::OP_SCAN;
				if (st.found) begin
					state_n = pbra_pkg::ST_WALK;
				end else if (st.scan_end) begin
					state_n = st.lo_empty ? pbra_pkg::ST_DONE : pbra_pkg::ST_START_LO;
				end
			end
			pbra_pkg::ST_START_LO: begin
				op      = pbra_pkg::OP_START_LO;
				state_n = pbra_pkg::ST_SCAN_LO;
			end
			pbra_pkg::ST_SCAN_LO: begin
				op = pbra_pkg::OP_SCAN;
				if (st.found) begin
					state_n = pbra_pkg::ST_WALK;
				end else if (st.scan_end) begin
					state_n = pbra_pkg::ST_DONE;
				end
			end
			pbra_pkg::ST_FREE_RD: begin
				state_n = pbra_pkg::ST_FREE_CHK;
			end
			pbra_pkg::ST_FREE_CHK: begin
				op      = pbra_pkg::OP_RELEASE;
				state_n = st.run_zero ? pbra_pkg::ST_DONE : pbra_pkg::ST_WALK;
			end
			pbra_pkg::ST_WALK: begin
				op = pbra_pkg::OP_WALK;
				if (st.walk_done) state_n = pbra_pkg::ST_DONE;
			end
			pbra_pkg::ST_DONE: begin
				if (!st.out_busy) begin
					op      = pbra_pkg::OP_FINISH;
					state_n = pbra_pkg::ST_IDLE;
				end
			end
			default: state_n = pbra_pkg::ST_CLEAR;
		endcase
	end
endmodule
`default_nettype wire

FILE: rtl/pbra_dp.sv
// Datapath: configuration, bitmap and run-length stores, scan, bookkeeping and result register.
`default_nettype none
module pbra_dp #(
	parameter int MAX_PAGES = pbra_pkg::MAX_PAGES_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire [pbra_pkg::REG_IDX_W-1:0]       cfg_index,
	input  wire [pbra_pkg::ADDR_W-1:0]          cfg_data,
	input  wire                                 req_type,
	input  wire [pbra_pkg::BYTES_W-1:0]         request_bytes,
	input  wire [pbra_pkg::ADDR_W-1:0]          free_address,
	input  wire                                 out_ready,
	output logic                                out_valid,
	output logic                                granted,
	output logic [pbra_pkg::ADDR_W-1:0]         granted_address,
	output logic [pbra_pkg::CNT_W-1:0]          pages_released,
	output logic [pbra_pkg::CNT_W-1:0]          live_count,
	output logic [pbra_pkg::CNT_W-1:0]          peak_count,
	input  pbra_pkg::op_t                       op,
	output pbra_pkg::stat_t                     st
);
	localparam int PW = $clog2(MAX_PAGES);
	localparam int IW = PW + 1;
	localparam int CW = pbra_pkg::CNT_W;
	localparam int AW = pbra_pkg::ADDR_W;
	localparam int PS = pbra_pkg::PAGE_SHIFT;

	logic          en_q;
	logic [CW-1:0] arena_pages_q;
	logic [AW-1:0] base_q;

	logic [PW-1:0] clr_q;
	logic          req_free_q;
	logic [CW-1:0] need_q;
	logic [PW-1:0] idx_q;
	logic [IW-1:0] pages_q;
	logic [PW-1:0] hint_q;
	logic [CW-1:0] live_q, peak_q;
	logic [IW-1:0] nxt_q, hi_q, pos_s1;
	logic          v_s1;
	logic [CW-1:0] run_q;
	logic [CW-1:0] mcnt_q;
	logic          walk_val_q;
	logic          res_ok_q;
	logic [AW-1:0] res_addr_q;
	logic [CW-1:0] res_rel_q;
	logic          out_valid_q;
	logic          out_ok_q;
	logic [AW-1:0] out_addr_q;
	logic [CW-1:0] out_rel_q, out_live_q, out_peak_q;

	logic          used_rdata;
	logic [CW-1:0] run_rdata;
	logic          used_we, run_we, used_wdata;
	logic [PW-1:0] used_waddr, run_waddr;
	logic [CW-1:0] run_wdata;

	logic [31:0]    eff32;
	logic [IW-1:0]  pages_eff;
	logic [32:0]    bsum;
	logic [20:0]    need21;
	logic [AW:0]    fdiff;
	logic [AW-PS-1:0] fpage;
	logic           alloc_ok, free_ok;
	logic [PW-1:0]  hint_eff;
	logic           issue, found;
	logic [31:0]    at32, end32;
	logic [PW-1:0]  at;
	logic [CW-1:0]  live_n;

	always_comb begin
		eff32     = (32'(arena_pages_q) > 32'(MAX_PAGES)) ? 32'(MAX_PAGES) : 32'(arena_pages_q);
		pages_eff = eff32[IW-1:0];
		bsum      = {1'b0, request_bytes} + 33'(pbra_pkg::PAGE_BYTES - 1);
		need21    = bsum[32:PS];
		alloc_ok  = en_q && (need21 != '0) && (32'(need21) <= 32'(pages_eff));
		fdiff     = {1'b0, free_address} - {1'b0, base_q};
		fpage     = fdiff[AW-1:PS];
		free_ok   = en_q && !fdiff[AW] && (fpage < (AW-PS)'(pages_eff));
		hint_eff  = (32'(hint_q) < 32'(pages_q)) ? hint_q : '0;
		issue     = (op == pbra_pkg::OP_SCAN) && (nxt_q < hi_q);
		found     = (op == pbra_pkg::OP_SCAN) && v_s1 && !used_rdata &&
		            (32'(run_q) + 32'd1 == 32'(need_q));
		end32     = 32'(pos_s1) + 32'd1;
		at32      = end32 - 32'(need_q);
		at        = at32[PW-1:0];
		live_n    = live_q + need_q;
	end

	always_comb begin
		st.clear_done = (clr_q == PW'(MAX_PAGES - 1));
		st.is_free    = (req_type == pbra_pkg::REQ_FREE);
		st.alloc_ok   = alloc_ok;
		st.free_ok    = free_ok;
		st.found      = found;
		st.scan_end   = !v_s1 && (nxt_q >= hi_q);
		st.lo_empty   = (hint_eff == '0);
		st.run_zero   = (run_rdata == '0);
		st.walk_done  = (mcnt_q == CW'(1)) || (idx_q == PW'(MAX_PAGES - 1));
		st.out_busy   = out_valid_q && !out_ready;
	end

	always_comb begin
		used_we    = (op == pbra_pkg::OP_CLEAR) || (op == pbra_pkg::OP_WALK);
		used_waddr = (op == pbra_pkg::OP_CLEAR) ? clr_q : idx_q;
		used_wdata = (op == pbra_pkg::OP_WALK) && walk_val_q;
		run_we     = (op == pbra_pkg::OP_CLEAR) || found ||
		             ((op == pbra_pkg::OP_RELEASE) && (run_rdata != '0));
		run_waddr  = (op == pbra_pkg::OP_CLEAR) ? clr_q : (found ? at : idx_q);
		run_wdata  = found ? need_q : '0;
	end

	pbra_ram #(.WIDTH(1), .DEPTH(MAX_PAGES)) u_used (
		.clk   (clk),
		.we    (used_we),
		.waddr (used_waddr),
		.wdata (used_wdata),
		.raddr (nxt_q[PW-1:0]),
		.rdata (used_rdata)
	);

	pbra_ram #(.WIDTH(CW), .DEPTH(MAX_PAGES)) u_run (
		.clk   (clk),
		.we    (run_we),
		.waddr (run_waddr),
		.wdata (run_wdata),
		.raddr (idx_q),
		.rdata (run_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q          <= 1'b0;
			arena_pages_q <= CW'(1024);
			base_q        <= '0;
			clr_q         <= '0;
			hint_q        <= '0;
			live_q        <= '0;
			peak_q        <= '0;
			v_s1          <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					pbra_pkg::REG_ARENA_ENABLE: en_q          <= cfg_data[0];
					pbra_pkg::REG_ARENA_PAGES:  arena_pages_q <= cfg_data[CW-1:0];
					pbra_pkg::REG_ARENA_BASE:   base_q        <= cfg_data;
					default: ;
				endcase
			end
			if (op == pbra_pkg::OP_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (op)
				pbra_pkg::OP_CLEAR: clr_q <= clr_q + PW'(1);
				pbra_pkg::OP_START_HI, pbra_pkg::OP_START_LO: v_s1 <= 1'b0;
				pbra_pkg::OP_SCAN: begin
					v_s1 <= issue;
					if (found) begin
						hint_q <= (end32 >= 32'(pages_q)) ? '0 : end32[PW-1:0];
						live_q <= live_n;
						if (live_n > peak_q) peak_q <= live_n;
					end
				end
				pbra_pkg::OP_RELEASE: begin
					if (run_rdata != '0) begin
						live_q <= (live_q >= run_rdata) ? live_q - run_rdata : '0;
						if (idx_q < hint_q) hint_q <= idx_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			pbra_pkg::OP_ACCEPT: begin
				req_free_q <= req_type;
				need_q     <= need21[CW-1:0];
				idx_q      <= fpage[PW-1:0];
				pages_q    <= pages_eff;
				res_ok_q   <= 1'b0;
				res_addr_q <= '0;
				res_rel_q  <= '0;
			end
			pbra_pkg::OP_START_HI: begin
				nxt_q <= IW'(hint_eff);
				hi_q  <= pages_q;
				run_q <= '0;
			end
			pbra_pkg::OP_START_LO: begin
				nxt_q <= '0;
				hi_q  <= IW'(hint_eff);
				run_q <= '0;
			end
			pbra_pkg::OP_SCAN: begin
				pos_s1 <= nxt_q;
				if (issue) nxt_q <= nxt_q + IW'(1);
				if (v_s1) run_q <= used_rdata ? '0 : run_q + CW'(1);
				if (found) begin
					idx_q      <= at;
					mcnt_q     <= need_q;
					walk_val_q <= 1'b1;
					res_ok_q   <= 1'b1;
					res_addr_q <= base_q + (AW'(at32) << PS);
				end
			end
			pbra_pkg::OP_RELEASE: begin
				mcnt_q     <= run_rdata;
				walk_val_q <= 1'b0;
				if (run_rdata != '0) begin
					res_ok_q  <= 1'b1;
					res_rel_q <= run_rdata;
				end
			end
			pbra_pkg::OP_WALK: begin
				idx_q  <= idx_q + PW'(1);
				mcnt_q <= mcnt_q - CW'(1);
			end
			pbra_pkg::OP_FINISH: begin
				out_ok_q   <= res_ok_q;
				out_addr_q <= res_addr_q;
				out_rel_q  <= res_rel_q;
				out_live_q <= live_q;
				out_peak_q <= peak_q;
			end
			default: ;
		endcase
	end

	assign out_valid       = out_valid_q;
	assign granted         = out_ok_q;
	assign granted_address = out_addr_q;
	assign pages_released  = out_rel_q;
	assign live_count      = out_live_q;
	assign peak_count      = out_peak_q;

`ifndef NO_ASSERTIONS
	a_peak_ge_live: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= live_q) else $error("peak below live");
	a_walk_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(op == pbra_pkg::OP_WALK) |-> (mcnt_q != '0)) else $error("walk with zero count");
	a_found_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		found |-> (end32 <= 32'(hi_q) && !req_free_q)) else $error("run outside scan range");
`endif
endmodule
`default_nettype wire
